/* rtl/core/cfp_pkg.sv */
// cfp_pkg: shared types, register indexes and action codes for the command frame parser
// no dependencies

package cfp_pkg;

  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_MOTION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TEMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_BATTERY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_NAME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_RST_REQ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_AUTORST = 3'd6;

  // reset value of the start byte configuration register
  localparam logic [7:0] RST_START_BYTE = 8'h02;

  // action codes
  localparam logic [2:0] ACT_NONE = 3'd0;

  typedef struct packed {
    logic [7:0]                      start_byte;
    logic [NUM_CODES-1:0][7:0]       codes;
  } cfg_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] frame_address;
    logic [2:0]  action_code;
    logic [7:0]  frame_command;
  } res_t;

  // first matching command code wins, action k+1 for code k
  function automatic logic [2:0] decode_action(cfg_t c, logic [7:0] cmd);
    logic [2:0] act;
    act = ACT_NONE;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (c.codes[k] == cmd) begin
        act = 3'(k + 1);
      end
    end
    return act;
  endfunction

endpackage

/* rtl/core/cfp_cfg_regs.sv */
// cfp_cfg_regs: start byte and command code registers behind the write port
// depends on cfp_pkg

module cfp_cfg_regs import cfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_START_BYTE:   cfg_nxt.start_byte = wr_data;
        REG_CODE_MOTION:  cfg_nxt.codes[0]   = wr_data;
        REG_CODE_TEMP:    cfg_nxt.codes[1]   = wr_data;
        REG_CODE_BATTERY: cfg_nxt.codes[2]   = wr_data;
        REG_CODE_NAME:    cfg_nxt.codes[3]   = wr_data;
        REG_CODE_RST_REQ: cfg_nxt.codes[4]   = wr_data;
        REG_CODE_AUTORST: cfg_nxt.codes[5]   = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= RST_START_BYTE;
      for (int k = 0; k < NUM_CODES; k++) begin
        cfg_r.codes[k] <= 8'(k + 1);
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/cfp_framer.sv */
// cfp_framer: frame phase state machine, held command/address and running checksum
// depends on cfp_pkg

module cfp_framer import cfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  input  logic       step,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_CMD     = 5'b00010,
    PH_ADDR_HI = 5'b00100,
    PH_ADDR_LO = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        sum_ok;

  assign sum_ok = (sum_r == rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    sum_nxt   = sum_r;
    unique case (phase_r)
      PH_START: begin
        if (rx_byte == cfg.start_byte) begin
          cmd_nxt   = 8'h00;
          addr_nxt  = 16'h0000;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = rx_byte;
        phase_nxt = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        addr_nxt  = {rx_byte, 8'h00};
        sum_nxt   = sum_r + rx_byte;
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        addr_nxt  = {addr_r[15:8], rx_byte};
        sum_nxt   = sum_r + rx_byte;
        phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (!sum_ok) begin
          cmd_nxt  = 8'h00;
          addr_nxt = 16'h0000;
        end
        phase_nxt = PH_START;
      end
      default: phase_nxt = PH_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cmd_r   <= 8'h00;
      addr_r  <= 16'h0000;
      sum_r   <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // result only on the checksum byte
  assign res_valid         = byte_valid && (phase_r == PH_CHECK);
  assign res.checksum_ok   = sum_ok;
  assign res.frame_address = addr_r;
  assign res.action_code   = sum_ok ? decode_action(cfg, cmd_r) : ACT_NONE;
  assign res.frame_command = cmd_r;

endmodule

/* rtl/core/command_frame_parser.sv */
// command_frame_parser: top level, input byte register, framer and result register
// depends on cfp_pkg, cfp_cfg_regs, cfp_framer
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall   in_rx_byte
//   out_     out        out_valid/out_stall out_checksum_ok, out_frame_address,
//                                           out_action_code, out_frame_command
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a result is registered after its checksum
// byte, which passes the input register, then framer logic into the result register
// synchronous active-low reset restores every register but the held byte and result data
// bytes that make no result pass while a result waits on out_stall
// cfg_ready is always high; writes to index seven are dropped

module command_frame_parser import cfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_checksum_ok,
  output logic [15:0]          out_frame_address,
  output logic [2:0]           out_action_code,
  output logic [7:0]           out_frame_command,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t       cfg;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       res_valid;
  res_t       res;
  logic       out_free;
  logic       step;
  logic       in_take;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  assign cfg_ready = 1'b1;

  cfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cfp_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .byte_valid (s1_valid_r),
    .rx_byte    (s1_byte_r),
    .step       (step),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  // held byte moves on unless it makes a result that cannot be stored yet
  assign step     = s1_valid_r && (!res_valid || out_free);
  assign in_stall = s1_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !step);
  assign out_valid_nxt = (step && res_valid) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_checksum_ok   = out_res_r.checksum_ok;
  assign out_frame_address = out_res_r.frame_address;
  assign out_action_code   = out_res_r.action_code;
  assign out_frame_command = out_res_r.frame_command;

`ifndef SYNTHESIS
  // a bad checksum never carries an action
  a_bad_sum_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_checksum_ok |-> out_action_code == ACT_NONE)
    else $error("action code given with bad checksum");

  // input is held back only while a byte waits in the input register
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // a result moved into the output register shows up next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid |=> out_valid)
    else $error("result lost on its way to the output register");

  // a waiting result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !(step && res_valid))
    else $error("pending result overwritten");
`endif

endmodule
